// ----- hdl/kmd_pkg.sv -----
// kmd_pkg: shared types and constants for the key matrix debouncer.
// Transaction payload structs, key table entry layout and controller states.
// No dependencies.
`default_nettype none

package kmd_pkg;

    localparam int HOLD_W    = 20;
    localparam int KEY_W     = 7;
    localparam int ELAPSED_W = 32;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 3;

    localparam logic [HOLD_W-1:0] HOLDOFF_RESET = HOLD_W'(5000);

    // register index taken from the byte address
    localparam logic REG_HOLDOFF = 1'b0;

    localparam logic KIND_TICK   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef struct packed {
        logic                 kind;
        logic [ELAPSED_W-1:0] elapsed_us;
        logic [KEY_W-1:0]     key_index;
        logic                 contact_closed;
        logic                 scan_start;
    } kmd_in_t;

    typedef struct packed {
        logic [KEY_W-1:0] key_out;
        logic             debounced_down;
        logic             press_seen;
        logic             tick_done;
    } kmd_out_t;

    typedef struct packed {
        logic              down;
        logic [HOLD_W-1:0] hold;
    } kmd_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SAMPLE,
        ST_TICK,
        ST_TDONE
    } kmd_state_t;

endpackage

`default_nettype wire

// ----- hdl/kmd_ram.sv -----
// kmd_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module kmd_ram #(
    parameter int WIDTH = 21,
    parameter int DEPTH = 128
) (
    input  wire logic                               clk,
    input  wire logic                               we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                   wdata,
    input  wire logic                               re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                   rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- hdl/key_matrix_debounce.sv -----
// key_matrix_debounce: top level of the eager-press, delayed-release debouncer.
// Depends on kmd_pkg and kmd_ram.
`default_nettype none

// Per-key state (down flag and hold-off countdown) lives in one RAM entry per
// key, read and written back through a single read port and a single write
// port. A key sample issues the RAM read at acceptance and then, in ST_SAMPLE,
// does the read-modify-write that also loads the result register. A time
// tick walks the whole table, one entry per cycle. Reset state comes from
// per-entry valid flops (an entry never written reads as released with zero
// countdown), so there is no clearing pass. The next transaction is taken
// while a result still waits in the output register; the block only stalls
// when a second result is ready.

module key_matrix_debounce
    import kmd_pkg::*;
#(
    parameter int NUM_KEYS = 128
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // input items
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire kmd_in_t           in_data,
    // results
    output logic                   out_valid,
    input  wire logic              out_ready,
    output kmd_out_t               out_data,
    // configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    localparam int AW    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int IDX_W = 9;
    localparam int ENT_W = $bits(kmd_entry_t);
    localparam logic [AW-1:0]    LAST_ADDR = AW'(NUM_KEYS - 1);
    localparam logic [IDX_W-1:0] NUM_KEYS_X = IDX_W'(NUM_KEYS);

    kmd_state_t         state_reg, state_next;
    kmd_in_t            item_reg;
    logic [AW-1:0]      addr_reg, addr_next;
    logic [NUM_KEYS-1:0] valid_reg;
    logic               press_reg, press_next;
    logic [HOLD_W-1:0]  holdoff_reg;
    logic               out_valid_reg, out_valid_next;
    kmd_out_t           out_data_reg, out_data_next;

    logic               accept;
    logic               out_free;
    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_raddr;
    kmd_entry_t         ram_wdata;
    logic [ENT_W-1:0]   ram_rdata;
    kmd_entry_t         cur;
    logic [IDX_W-1:0]   in_idx_x, item_idx_x;
    logic               in_range;
    kmd_entry_t         sample_new;
    kmd_entry_t         tick_new;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holdoff_reg <= HOLDOFF_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_HOLDOFF))
        begin
            holdoff_reg <= pwdata[HOLD_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_HOLDOFF)
        begin
            prdata = {{(DATA_W-HOLD_W){1'b0}}, holdoff_reg};
        end
    end

    // ------------------------------------------------------------------
    // key table
    // ------------------------------------------------------------------
    kmd_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NUM_KEYS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // an entry never written reads as its reset value
    assign cur = valid_reg[addr_reg] ? kmd_entry_t'(ram_rdata) : '0;

    assign in_idx_x   = {{(IDX_W-KEY_W){1'b0}}, in_data.key_index};
    assign item_idx_x = {{(IDX_W-KEY_W){1'b0}}, item_reg.key_index};
    assign in_range   = item_idx_x < NUM_KEYS_X;

    always_comb
    begin
        sample_new = cur;
        if (item_reg.contact_closed)
        begin
            sample_new.down = 1'b1;
            if (!cur.down)
            begin
                sample_new.hold = holdoff_reg;
            end
        end
        else if (cur.hold == '0)
        begin
            sample_new.down = 1'b0;
        end
    end

    always_comb
    begin
        tick_new = cur;
        if ({{(ELAPSED_W-HOLD_W){1'b0}}, cur.hold} <= item_reg.elapsed_us)
        begin
            tick_new.hold = '0;
        end
        else
        begin
            tick_new.hold = cur.hold - item_reg.elapsed_us[HOLD_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // controller
    // ------------------------------------------------------------------
    assign out_free = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        press_next     = press_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        in_ready       = 1'b0;
        ram_re         = 1'b0;
        ram_raddr      = in_idx_x[AW-1:0];
        ram_we         = 1'b0;
        ram_wdata      = sample_new;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ram_re = 1'b1;
                    if (in_data.kind == KIND_SAMPLE)
                    begin
                        addr_next  = in_idx_x[AW-1:0];
                        state_next = ST_SAMPLE;
                    end
                    else
                    begin
                        ram_raddr  = '0;
                        addr_next  = '0;
                        state_next = ST_TICK;
                    end
                end
            end

            ST_SAMPLE:
            begin
                if (out_free)
                begin
                    ram_we     = in_range;
                    ram_wdata  = sample_new;
                    press_next = (press_reg && !item_reg.scan_start)
                                 || (in_range && item_reg.contact_closed);
                    out_valid_next               = 1'b1;
                    out_data_next.key_out        = item_reg.key_index;
                    out_data_next.debounced_down = in_range && sample_new.down;
                    out_data_next.press_seen     = press_next;
                    out_data_next.tick_done      = 1'b0;
                    state_next                   = ST_IDLE;
                end
            end

            ST_TICK:
            begin
                // only pressed keys can carry a nonzero countdown
                ram_we    = cur.down;
                ram_wdata = tick_new;
                if (addr_reg == LAST_ADDR)
                begin
                    state_next = ST_TDONE;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = addr_reg + 1'b1;
                    addr_next  = addr_reg + 1'b1;
                end
            end

            ST_TDONE:
            begin
                if (out_free)
                begin
                    out_valid_next               = 1'b1;
                    out_data_next.key_out        = '0;
                    out_data_next.debounced_down = 1'b0;
                    out_data_next.press_seen     = press_reg;
                    out_data_next.tick_done      = 1'b1;
                    state_next                   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            addr_reg      <= '0;
            valid_reg     <= '0;
            press_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            press_reg     <= press_next;
            out_valid_reg <= out_valid_next;
            if (ram_we)
            begin
                valid_reg[addr_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_data;
        end
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_we_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_SAMPLE || state_reg == ST_TICK))
        else $error("key table written outside a sample or tick");

    a_press_set: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SAMPLE && out_free && in_range && item_reg.contact_closed)
        |=> press_reg)
        else $error("press-seen flag not set after closed contact");

    a_tick_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TICK && addr_reg != LAST_ADDR)
        |=> (state_reg == ST_TICK && addr_reg == $past(addr_reg) + 1'b1))
        else $error("tick walk skipped an entry");

    a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TDONE && out_free)
        |=> (out_valid && out_data.tick_done && out_data.key_out == '0))
        else $error("tick result malformed");

endmodule

`default_nettype wire
